>>> sv/rau_pkg.sv
package rau_pkg;

    localparam int WORD_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ZERO_DEN     = 2'd1,
        ST_DIV_ZERO     = 2'd2,
        ST_RES_DEN_ZERO = 2'd3
    } t_status;

    // which fraction the normaliser is working on
    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_CHK,
        S_GCD_INIT,
        S_GCD_TEST,
        S_DIV,
        S_GCD_NEXT,
        S_QN,
        S_QD,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_OUT
    } t_state;

endpackage

>>> sv/rational_arithmetic_unit_top.sv
// Fraction arithmetic unit: takes two signed fractions a_num/a_den and b_num/b_den plus an
// operation (add, subtract, multiply, divide) and returns the reduced result with the sign
// on the numerator. Each operand is normalised first (negative denominator moves its sign
// up, then both parts are divided by their Euclidean gcd), the cross products are formed
// and the result is normalised the same way. All intermediates wrap to WORD_BITS-bit two's
// complement and o_overflow reports any wrap. Errors give a 0/0 result with o_status set:
// 1 operand zero denominator, 2 divide by a zero fraction, 3 product denominator wrapped to
// zero. One transaction is handled at a time; o_req_ready is high only while idle. Latency
// is data dependent: every modulo step and each of the two exact divisions of a
// normalisation runs on one shared restoring divider, each run framed by control states,
// and a transaction takes its three normalisations plus the idle, multiply and output
// states from one accepted request to the next. A finished result sits in the output
// register until taken.
module rational_arithmetic_unit_top #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_a_num,
    input  logic signed [15:0] i_a_den,
    input  logic signed [15:0] i_b_num,
    input  logic signed [15:0] i_b_den,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic signed [15:0] o_res_num,
    output logic [14:0]        o_res_den,
    output logic [1:0]         o_status,
    output logic               o_overflow
);

    localparam int W  = WORD_BITS;
    localparam int SW = 2 * WORD_BITS + 1;
    localparam int CW = $clog2(WORD_BITS);
    localparam logic [W-1:0] SIGN_MAG = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] f_abs(input logic [W-1:0] v);
        f_abs = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] f_sgn(input logic [W-1:0] q, input logic neg);
        f_sgn = neg ? (~q + 1'b1) : q;
    endfunction

    // control
    rau_pkg::t_state  r_state, n_state;
    rau_pkg::t_state  r_ret, n_ret;
    rau_pkg::t_phase  r_phase, n_phase;
    rau_pkg::t_status r_status, n_status;
    rau_pkg::t_op     r_op, n_op;
    logic             r_ovf, n_ovf;
    logic             r_res_valid;

    // operands and working fraction
    logic signed [W-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic signed [W-1:0] r_wn, n_wn, r_wd, n_wd;

    // gcd
    logic [W-1:0] r_gp, n_gp, r_gq, n_gq, r_g, n_g;

    // shared divider
    logic [W-1:0]  r_dv_rem, n_dv_rem, r_dv_quo, n_dv_quo, r_dv_dsr, n_dv_dsr;
    logic [CW-1:0] r_dv_cnt, n_dv_cnt;
    logic [W+1:0]  dv_trial;

    // shared multiplier
    logic signed [W-1:0]   mul_x, mul_y;
    logic signed [2*W-1:0] r_prod, n_prod, r_p1, n_p1;
    logic signed [SW-1:0]  sum_v;

    // output register
    logic signed [15:0] r_res_num, n_res_num;
    logic [14:0]        r_res_den, n_res_den;
    logic [1:0]         r_res_status, n_res_status;
    logic               r_res_ovf, n_res_ovf;

    logic out_free;
    logic gflip;

    assign out_free = !r_res_valid || i_res_ready;
    assign gflip    = (r_g == SIGN_MAG);
    assign dv_trial = {1'b0, r_dv_rem, r_dv_quo[W-1]} - {2'b00, r_dv_dsr};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rau_pkg::S_IDLE:     if (i_req_valid) n_state = rau_pkg::S_NORM_CHK;
            rau_pkg::S_NORM_CHK: n_state = (r_wd == '0) ? rau_pkg::S_OUT : rau_pkg::S_GCD_INIT;
            rau_pkg::S_GCD_INIT: n_state = rau_pkg::S_GCD_TEST;
            rau_pkg::S_GCD_TEST: n_state = rau_pkg::S_DIV;
            rau_pkg::S_DIV:      if (r_dv_cnt == '0) n_state = r_ret;
            rau_pkg::S_GCD_NEXT: n_state = rau_pkg::S_GCD_TEST;
            rau_pkg::S_QN:       n_state = rau_pkg::S_DIV;
            rau_pkg::S_QD: begin
                unique case (r_phase)
                    rau_pkg::PH_A: n_state = rau_pkg::S_NORM_CHK;
                    rau_pkg::PH_B: n_state = (r_op == rau_pkg::OP_DIV && r_wn == '0)
                                             ? rau_pkg::S_OUT : rau_pkg::S_MUL1;
                    default:       n_state = rau_pkg::S_OUT;
                endcase
            end
            rau_pkg::S_MUL1:     n_state = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:     n_state = rau_pkg::S_MUL3;
            rau_pkg::S_MUL3:     n_state = rau_pkg::S_MUL4;
            rau_pkg::S_MUL4:     n_state = rau_pkg::S_NORM_CHK;
            rau_pkg::S_OUT:      if (out_free) n_state = rau_pkg::S_IDLE;
            default:             n_state = rau_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [W-1:0] qd;
        n_ret = r_ret;  n_phase = r_phase;  n_status = r_status;
        n_op = r_op;    n_ovf = r_ovf;
        n_an = r_an;    n_ad = r_ad;  n_bn = r_bn;  n_bd = r_bd;
        n_wn = r_wn;    n_wd = r_wd;
        n_gp = r_gp;    n_gq = r_gq;  n_g = r_g;
        n_dv_rem = r_dv_rem;  n_dv_quo = r_dv_quo;
        n_dv_dsr = r_dv_dsr;  n_dv_cnt = r_dv_cnt;
        n_p1 = r_p1;
        n_res_num = r_res_num;  n_res_den = r_res_den;
        n_res_status = r_res_status;  n_res_ovf = r_res_ovf;
        mul_x = r_an;
        mul_y = r_bd;
        sum_v = SW'(r_p1);
        qd = f_sgn(r_dv_quo, r_wd[W-1] ^ gflip);

        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = rau_pkg::t_op'(i_req_type);
                    n_an     = W'(i_a_num);
                    n_ad     = W'(i_a_den);
                    n_bn     = W'(i_b_num);
                    n_bd     = W'(i_b_den);
                    n_wn     = W'(i_a_num);
                    n_wd     = W'(i_a_den);
                    n_phase  = rau_pkg::PH_A;
                    n_status = rau_pkg::ST_OK;
                    n_ovf    = 1'b0;
                end
            end
            rau_pkg::S_NORM_CHK: begin
                if (r_wd == '0) begin
                    n_status = (r_phase == rau_pkg::PH_R) ? rau_pkg::ST_RES_DEN_ZERO
                                                          : rau_pkg::ST_ZERO_DEN;
                end else if (r_wd[W-1]) begin
                    n_wn  = -r_wn;
                    n_wd  = -r_wd;
                    n_ovf = r_ovf || (r_wn == SIGN_MAG) || (r_wd == SIGN_MAG);
                end
            end
            rau_pkg::S_GCD_INIT: begin
                n_gp = f_abs(r_wn);
                n_gq = f_abs(r_wd);
            end
            rau_pkg::S_GCD_TEST: begin
                n_dv_rem = '0;
                n_dv_cnt = CW'(W - 1);
                if (r_gq == '0) begin
                    // gcd found; a magnitude of 2^(W-1) wraps negative
                    n_g      = r_gp;
                    n_ovf    = r_ovf || (r_gp == SIGN_MAG);
                    n_dv_quo = f_abs(r_wn);
                    n_dv_dsr = r_gp;
                    n_ret    = rau_pkg::S_QN;
                end else begin
                    n_dv_quo = r_gp;
                    n_dv_dsr = r_gq;
                    n_ret    = rau_pkg::S_GCD_NEXT;
                end
            end
            rau_pkg::S_DIV: begin
                // one restoring step per cycle
                if (!dv_trial[W+1]) begin
                    n_dv_rem = dv_trial[W-1:0];
                    n_dv_quo = {r_dv_quo[W-2:0], 1'b1};
                end else begin
                    n_dv_rem = {r_dv_rem[W-2:0], r_dv_quo[W-1]};
                    n_dv_quo = {r_dv_quo[W-2:0], 1'b0};
                end
                n_dv_cnt = r_dv_cnt - 1'b1;
            end
            rau_pkg::S_GCD_NEXT: begin
                n_gp = r_gq;
                n_gq = r_dv_rem;
            end
            rau_pkg::S_QN: begin
                n_wn     = f_sgn(r_dv_quo, r_wn[W-1] ^ gflip);
                n_dv_rem = '0;
                n_dv_cnt = CW'(W - 1);
                n_dv_quo = f_abs(r_wd);
                n_dv_dsr = r_g;
                n_ret    = rau_pkg::S_QD;
            end
            rau_pkg::S_QD: begin
                n_wd = qd;
                unique case (r_phase)
                    rau_pkg::PH_A: begin
                        n_an    = r_wn;
                        n_ad    = qd;
                        n_wn    = r_bn;
                        n_wd    = r_bd;
                        n_phase = rau_pkg::PH_B;
                    end
                    rau_pkg::PH_B: begin
                        n_bn = r_wn;
                        n_bd = qd;
                        if (r_op == rau_pkg::OP_DIV && r_wn == '0)
                            n_status = rau_pkg::ST_DIV_ZERO;
                    end
                    default: ;
                endcase
            end
            rau_pkg::S_MUL1: begin
                // result denominator product
                mul_x = r_ad;
                mul_y = (r_op == rau_pkg::OP_DIV) ? r_bn : r_bd;
            end
            rau_pkg::S_MUL2: begin
                mul_x = r_an;
                mul_y = (r_op == rau_pkg::OP_MUL) ? r_bn : r_bd;
                n_wd  = r_prod[W-1:0];
                n_ovf = r_ovf || (r_prod[2*W-1:W-1] != {(W+1){r_prod[W-1]}});
            end
            rau_pkg::S_MUL3: begin
                mul_x = r_bn;
                mul_y = r_ad;
                n_p1  = r_prod;
            end
            rau_pkg::S_MUL4: begin
                unique case (r_op)
                    rau_pkg::OP_ADD: sum_v = SW'(r_p1) + SW'(r_prod);
                    rau_pkg::OP_SUB: sum_v = SW'(r_p1) - SW'(r_prod);
                    default:         sum_v = SW'(r_p1);
                endcase
                n_wn    = sum_v[W-1:0];
                n_ovf   = r_ovf || (sum_v[SW-1:W-1] != {(SW-W+1){sum_v[W-1]}});
                n_phase = rau_pkg::PH_R;
            end
            rau_pkg::S_OUT: begin
                if (out_free) begin
                    if (r_status == rau_pkg::ST_OK) begin
                        n_res_num = 16'(r_wn);
                        n_res_den = 15'(r_wd);
                    end else begin
                        n_res_num = '0;
                        n_res_den = '0;
                    end
                    n_res_status = r_status;
                    n_res_ovf    = r_ovf;
                end
            end
            default: ;
        endcase
        n_prod = mul_x * mul_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rau_pkg::S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rau_pkg::S_OUT && out_free)
                r_res_valid <= 1'b1;
            else if (i_res_ready)
                r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;    r_phase  <= n_phase;  r_status <= n_status;
        r_op     <= n_op;     r_ovf    <= n_ovf;
        r_an     <= n_an;     r_ad     <= n_ad;     r_bn <= n_bn;  r_bd <= n_bd;
        r_wn     <= n_wn;     r_wd     <= n_wd;
        r_gp     <= n_gp;     r_gq     <= n_gq;     r_g  <= n_g;
        r_dv_rem <= n_dv_rem; r_dv_quo <= n_dv_quo;
        r_dv_dsr <= n_dv_dsr; r_dv_cnt <= n_dv_cnt;
        r_prod   <= n_prod;   r_p1     <= n_p1;
        r_res_num    <= n_res_num;
        r_res_den    <= n_res_den;
        r_res_status <= n_res_status;
        r_res_ovf    <= n_res_ovf;
    end

    assign o_req_ready = (r_state == rau_pkg::S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_status    = r_res_status;
    assign o_overflow  = r_res_ovf;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF    = 6;
    // long enough that a result always completes and waits, stalling the input
    localparam int LONG_HOLD   = 4000;
    localparam int CYCLE_LIMIT = 6_000_000;

    typedef struct {
        logic signed [15:0] num;
        logic [14:0]        den;
        rau_pkg::t_status   status;
        logic               ovf;
    } t_frac_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_req_valid = 1'b0;
    logic               o_req_ready;
    logic [1:0]         i_req_type = rau_pkg::OP_ADD;
    logic signed [15:0] i_a_num = '0;
    logic signed [15:0] i_a_den = '0;
    logic signed [15:0] i_b_num = '0;
    logic signed [15:0] i_b_den = '0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic signed [15:0] o_res_num;
    logic [14:0]        o_res_den;
    logic [1:0]         o_status;
    logic               o_overflow;

    rational_arithmetic_unit_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_type  (i_req_type),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_status    (o_status),
        .o_overflow  (o_overflow)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // expected results, oldest first
    t_frac_result frac_expected_q[$];
    int  sent_cnt = 0;
    int  got_cnt = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    int  ovf_seen = 0;
    bit  quiet_mode = 1'b0;   // no idling on either side
    bit  hold_req = 1'b0;     // ask the receiver for a long hold-off
    int  hold_cnt = 0;
    bit  wrap_flag;

    // ---------------------------------------------------------------
    // fraction predictor: 16-bit wrapping arithmetic with gcd reduction
    // ---------------------------------------------------------------
    function automatic longint wrap16(longint v);
        return longint'(shortint'(v[15:0]));
    endfunction

    // store into a word, remember any wrap
    function automatic longint keep16(longint v);
        longint r;
        r = wrap16(v);
        if (r != v)
            wrap_flag = 1'b1;
        return r;
    endfunction

    function automatic longint euclid(longint p, longint q);
        longint t;
        while (q != 0) begin
            t = q;
            q = p % q;
            p = t;
        end
        return keep16(p < 0 ? -p : p);
    endfunction

    // reduce n/d with sign on the numerator; 0 when the denominator is zero
    function automatic bit reduce_frac(inout longint n, inout longint d);
        longint g;
        if (d == 0)
            return 1'b0;
        if (d < 0) begin
            n = keep16(-n);
            d = keep16(-d);
        end
        g = euclid(n, d);
        if (g == 0)
            g = 1;
        n = keep16(n / g);
        d = keep16(d / g);
        return 1'b1;
    endfunction

    function automatic t_frac_result predict_fraction(rau_pkg::t_op op,
                                                      logic signed [15:0] a_n,
                                                      logic signed [15:0] a_d,
                                                      logic signed [15:0] b_n,
                                                      logic signed [15:0] b_d);
        longint an, ad, bn, bd, rn, rd;
        rau_pkg::t_status st;
        t_frac_result res;
        an = a_n; ad = a_d; bn = b_n; bd = b_d;
        rn = 0; rd = 0;
        st = rau_pkg::ST_OK;
        wrap_flag = 1'b0;
        if (!reduce_frac(an, ad) || !reduce_frac(bn, bd)) begin
            st = rau_pkg::ST_ZERO_DEN;
        end else if (op == rau_pkg::OP_DIV && bn == 0) begin
            st = rau_pkg::ST_DIV_ZERO;
        end else begin
            case (op)
                rau_pkg::OP_ADD: begin
                    rn = keep16(an * bd + bn * ad);
                    rd = keep16(ad * bd);
                end
                rau_pkg::OP_SUB: begin
                    rn = keep16(an * bd - bn * ad);
                    rd = keep16(ad * bd);
                end
                rau_pkg::OP_MUL: begin
                    rn = keep16(an * bn);
                    rd = keep16(ad * bd);
                end
                default: begin
                    rn = keep16(an * bd);
                    rd = keep16(ad * bn);
                end
            endcase
            if (!reduce_frac(rn, rd))
                st = rau_pkg::ST_RES_DEN_ZERO;
        end
        if (st != rau_pkg::ST_OK) begin
            rn = 0;
            rd = 0;
        end
        res.num    = rn[15:0];
        res.den    = rd[14:0];
        res.status = st;
        res.ovf    = wrap_flag;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // sender: one transaction, with an optional random gap first
    // ---------------------------------------------------------------
    task automatic send_fraction_req(rau_pkg::t_op op, logic signed [15:0] a_n,
                                     logic signed [15:0] a_d,
                                     logic signed [15:0] b_n, logic signed [15:0] b_d);
        if (!quiet_mode && $urandom_range(99) < 6) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req_type  <= op;
        i_a_num     <= a_n;
        i_a_den     <= a_d;
        i_b_num     <= b_n;
        i_b_den     <= b_d;
        // values read here are the ones from just before the edge
        do
            @(posedge i_clk);
        while (!(i_req_valid && o_req_ready));
        frac_expected_q.push_back(predict_fraction(op, a_n, a_d, b_n, b_d));
        sent_cnt++;
    endtask

    task automatic drop_valid_and_drain();
        i_req_valid <= 1'b0;
        wait (got_cnt == sent_cnt);
        @(posedge i_clk);
    endtask

    // a field value: mostly small for real reductions, some extremes, some full range
    function automatic logic signed [15:0] pick_field();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return 16'($signed($urandom_range(40)) - 20);
        else if (sel < 65) begin
            case ($urandom_range(5))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh0001;
                3: return -16'sh0001;
                4: return 16'sh0000;
                default: return 16'sh8001;
            endcase
        end else if (sel < 80)
            return 16'($signed($urandom_range(600)) - 300);
        return 16'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stalls, long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD;
        end
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_res_ready <= 1'b0;
        end else if (quiet_mode) begin
            i_res_ready <= 1'b1;
        end else begin
            i_res_ready <= ($urandom_range(99) >= 6);
        end
    end

    // result checker: each taken transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_frac_result exp_res;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (frac_expected_q.size() == 0) begin
                $error("result with nothing expected: num=%0d den=%0d", o_res_num, o_res_den);
                err_cnt++;
            end else begin
                exp_res = frac_expected_q.pop_front();
                if (o_res_num !== exp_res.num) begin
                    $error("res_num: expected %0d, got %0d", exp_res.num, o_res_num);
                    err_cnt++;
                end
                if (o_res_den !== exp_res.den) begin
                    $error("res_den: expected %0d, got %0d", exp_res.den, o_res_den);
                    err_cnt++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    err_cnt++;
                end
                if (o_overflow !== exp_res.ovf) begin
                    $error("overflow: expected %0d, got %0d", exp_res.ovf, o_overflow);
                    err_cnt++;
                end
                status_seen[exp_res.status]++;
                if (exp_res.ovf)
                    ovf_seen++;
            end
            got_cnt++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results", cycle_cnt, got_cnt,
                     sent_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // every operation plus the named corner cases
    task automatic test_directed();
        send_fraction_req(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_fraction_req(rau_pkg::OP_SUB, 1, 2, 1, 3);
        send_fraction_req(rau_pkg::OP_MUL, -4, 6, 3, -9);
        send_fraction_req(rau_pkg::OP_DIV, 5, 7, -10, 21);
        // zero denominator on a, then on b
        send_fraction_req(rau_pkg::OP_ADD, 3, 0, 1, 2);
        send_fraction_req(rau_pkg::OP_MUL, 3, 4, 1, 0);
        send_fraction_req(rau_pkg::OP_DIV, 0, 0, 0, 0);
        // divide by a zero fraction
        send_fraction_req(rau_pkg::OP_DIV, 3, 4, 0, 7);
        send_fraction_req(rau_pkg::OP_DIV, 0, 5, 0, -3);
        // product denominator wrapping to zero
        send_fraction_req(rau_pkg::OP_MUL, 1, 256, 1, 256);
        send_fraction_req(rau_pkg::OP_ADD, 1, 512, 1, 128);
        // most negative denominator and numerator
        send_fraction_req(rau_pkg::OP_ADD, 1, -32768, 0, 1);
        send_fraction_req(rau_pkg::OP_MUL, -32768, 1, 1, 1);
        send_fraction_req(rau_pkg::OP_SUB, -32768, -32768, 1, 1);
        send_fraction_req(rau_pkg::OP_DIV, 32767, 1, -32768, 3);
        send_fraction_req(rau_pkg::OP_ADD, 32767, 1, 32767, 1);
        send_fraction_req(rau_pkg::OP_MUL, 32767, 32767, -32768, -32768);
        send_fraction_req(rau_pkg::OP_SUB, 0, 1, 0, -1);
        send_fraction_req(rau_pkg::OP_DIV, -1, -1, -1, -1);
        send_fraction_req(rau_pkg::OP_ADD, 255, 257, 12, 18);
        drop_valid_and_drain();
    endtask

    task automatic test_random(int n_items);
        for (int k = 0; k < n_items; k++) begin
            // a stretch with no idling at all in the middle
            quiet_mode = (k >= n_items / 3) && (k < n_items / 3 + 150);
            send_fraction_req(rau_pkg::t_op'($urandom_range(3)), pick_field(), pick_field(),
                              pick_field(), pick_field());
        end
        quiet_mode = 1'b0;
        drop_valid_and_drain();
    endtask

    // receiver holds off while the sender keeps offering, so the block stalls its input
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_fraction_req(rau_pkg::t_op'($urandom_range(3)), pick_field(), pick_field(),
                              pick_field(), pick_field());
        drop_valid_and_drain();
    endtask

    // sender pauses until all results are back, then goes on
    task automatic test_drain_pause();
        for (int k = 0; k < 10; k++)
            send_fraction_req(rau_pkg::t_op'($urandom_range(3)), pick_field(), pick_field(),
                              pick_field(), pick_field());
        drop_valid_and_drain();
        for (int k = 0; k < 10; k++)
            send_fraction_req(rau_pkg::t_op'($urandom_range(3)), pick_field(), pick_field(),
                              pick_field(), pick_field());
        drop_valid_and_drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(1000);
        test_drain_pause();

        wait (got_cnt == sent_cnt);
        repeat (100) @(posedge i_clk);
        $display("covered %0d transactions: ok %0d, zero den %0d, div by zero %0d",
                 got_cnt, status_seen[0], status_seen[1], status_seen[2]);
        $display("result den zero %0d, with overflow %0d, leftover %0d",
                 status_seen[3], ovf_seen, frac_expected_q.size());
        if (err_cnt == 0 && frac_expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
